// ===== design/pnps_pkg.sv =====
// ----------------------------------------------------------------------------
// pnps_pkg
// Shared constants for the polyline nearest-point snap block.
// ----------------------------------------------------------------------------
`default_nettype none
package pnps_pkg;
    // Widest coordinate the datapath carries, keeps every product in range
    localparam int CoordCap = 29;
endpackage
`default_nettype wire

// ===== design/pnps_mul.sv =====
// ----------------------------------------------------------------------------
// pnps_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module pnps_mul #(
    parameter int OP_BITS = 30
) (
    input  wire logic                          aclk,
    input  wire logic signed [OP_BITS-1:0]     op_a,
    input  wire logic signed [OP_BITS-1:0]     op_b,
    output      logic signed [2*OP_BITS-1:0]   prod_reg
);
    // Register the product for the next sequencer step
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end
endmodule
`default_nettype wire

// ===== design/pnps_div.sv =====
// ----------------------------------------------------------------------------
// pnps_div
// Serial restoring divider: quotient of num * 2^RATIO_FRAC_BITS / den,
// one quotient bit per cycle, for 0 <= num <= den.
// ----------------------------------------------------------------------------
`default_nettype none
module pnps_div #(
    parameter int DIV_BITS        = 35,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [DIV_BITS-1:0]         num,
    input  wire logic [DIV_BITS-1:0]         den,
    output      logic                        done,
    output      logic [RATIO_FRAC_BITS:0]    quot
);
    localparam int CntBits = $clog2(RATIO_FRAC_BITS + 1);

    logic                      busy_reg;
    logic [CntBits-1:0]        cnt_reg;
    logic [DIV_BITS-1:0]       rem_reg;
    logic [DIV_BITS-1:0]       den_reg;
    logic [RATIO_FRAC_BITS:0]  quot_reg;
    logic                      done_reg;
    logic [DIV_BITS-1:0]       rem_shift;
    logic                      take;

    // First step compares without a shift, the rest shift the remainder
    always_comb begin
        rem_shift = (cnt_reg == '0) ? rem_reg : {rem_reg[DIV_BITS-2:0], 1'b0};
        take      = (rem_shift >= den_reg);
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntBits'(RATIO_FRAC_BITS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= take ? rem_shift - den_reg : rem_shift;
            quot_reg <= {quot_reg[RATIO_FRAC_BITS-1:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// ===== design/polyline_nearest_point_snap.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_point_snap
// Snaps a query point to the nearest point on a streamed polyline.
// ----------------------------------------------------------------------------
//  channel | prefix | payload
//  input   | s_     | query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex
//  result  | m_     | snap_x, snap_y, distance_sq
//
//  A first vertex skips the segment steps; a later one computes length and
//  dot product, and when the foot is tried the serial divider (one quotient
//  bit per cycle) and the single shared multiplier score the foot. s_ready is
//  high only between items. Reset clears the sequencer, query, previous and
//  best points and valid. A finished result waits in the output register; a
//  last vertex holds the sequencer until that register is free.
`default_nettype none
module polyline_nearest_point_snap #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0]      s_query_x,
    input  wire logic signed [COORD_BITS-1:0]      s_query_y,
    input  wire logic signed [COORD_BITS-1:0]      s_vertex_x,
    input  wire logic signed [COORD_BITS-1:0]      s_vertex_y,
    input  wire logic                              s_first_vertex,
    input  wire logic                              s_last_vertex,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic signed [COORD_BITS-1:0]      m_snap_x,
    output      logic signed [COORD_BITS-1:0]      m_snap_y,
    output      logic [2*((COORD_BITS > pnps_pkg::CoordCap) ? pnps_pkg::CoordCap
                         : COORD_BITS)+1-1:0]      m_distance_sq
);
    localparam int CW = (COORD_BITS > pnps_pkg::CoordCap) ? pnps_pkg::CoordCap : COORD_BITS;
    localparam int RF = RATIO_FRAC_BITS;
    localparam int MW = (CW + 1 > RF + 2) ? CW + 1 : RF + 2;
    localparam int PW = 2 * MW;
    localparam int DW = 2 * CW + 3;
    localparam int AW = 2 * CW + 4;
    localparam int BW = 2 * CW + 2;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LEN1 = 4'd1;
    localparam logic [3:0] ST_LEN2 = 4'd2;
    localparam logic [3:0] ST_LEN3 = 4'd3;
    localparam logic [3:0] ST_DOT1 = 4'd4;
    localparam logic [3:0] ST_DOT2 = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FX   = 4'd7;
    localparam logic [3:0] ST_FY   = 4'd8;
    localparam logic [3:0] ST_FD   = 4'd9;
    localparam logic [3:0] ST_D1   = 4'd10;
    localparam logic [3:0] ST_D2   = 4'd11;
    localparam logic [3:0] ST_D3   = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    logic [3:0]             state_reg;
    logic signed [CW-1:0]   qx_reg, qy_reg, prev_x_reg, prev_y_reg;
    logic signed [CW-1:0]   base_x_reg, base_y_reg, vx_reg, vy_reg;
    logic signed [CW-1:0]   cand_x_reg, cand_y_reg, best_x_reg, best_y_reg;
    logic signed [CW:0]     sx_reg, sy_reg, ex_reg, ey_reg;
    logic [BW-1:0]          best_dist_reg;
    logic [DW-1:0]          len_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [RF:0]            t_reg;
    logic                   first_reg, last_reg, foot_reg;
    logic                   m_valid_reg;
    logic signed [COORD_BITS-1:0] m_snap_x_reg, m_snap_y_reg;
    logic [2*CW:0]          m_dist_reg;

    logic signed [MW-1:0]   op_a, op_b;
    logic signed [PW-1:0]   prod;
    logic signed [AW-1:0]   sum;
    logic signed [PW-1:0]   foot_off;
    logic signed [CW:0]     dx, dy;
    logic                   div_start, div_done, try_foot;
    logic [RF:0]            div_quot;
    logic signed [CW-1:0]   in_vx, in_vy;
    logic                   load_result;

    assign in_vx = s_vertex_x[CW-1:0];
    assign in_vy = s_vertex_y[CW-1:0];
    assign s_ready = (state_reg == ST_IDLE);
    assign load_result = (state_reg == ST_FIN) && last_reg && (!m_valid_reg || m_ready);

    // Shared datapath terms
    always_comb begin
        sum      = acc_reg + AW'(prod);
        foot_off = prod >>> RF;
        dx       = (CW+1)'(qx_reg) - (CW+1)'(cand_x_reg);
        dy       = (CW+1)'(qy_reg) - (CW+1)'(cand_y_reg);
        try_foot = (len_reg != '0) && !sum[AW-1] && (sum[DW-1:0] <= len_reg);
        div_start = (state_reg == ST_DOT2) && try_foot;
    end

    // Select multiplier operands per step
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_LEN1: begin op_a = MW'(sx_reg); op_b = MW'(sx_reg); end
            ST_LEN2: begin op_a = MW'(sy_reg); op_b = MW'(sy_reg); end
            ST_LEN3: begin op_a = MW'(ex_reg); op_b = MW'(sx_reg); end
            ST_DOT1: begin op_a = MW'(ey_reg); op_b = MW'(sy_reg); end
            ST_FX:   begin op_a = MW'(sx_reg); op_b = $signed(MW'(t_reg)); end
            ST_FY:   begin op_a = MW'(sy_reg); op_b = $signed(MW'(t_reg)); end
            ST_D1:   begin op_a = MW'(dx); op_b = MW'(dx); end
            ST_D2:   begin op_a = MW'(dy); op_b = MW'(dy); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    pnps_mul #(.OP_BITS(MW)) u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    pnps_div #(.DIV_BITS(DW), .RATIO_FRAC_BITS(RF)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum[DW-1:0]),
        .den     (len_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            qx_reg        <= '0;
            qy_reg        <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_dist_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        vx_reg     <= in_vx;
                        vy_reg     <= in_vy;
                        first_reg  <= s_first_vertex;
                        last_reg   <= s_last_vertex;
                        base_x_reg <= prev_x_reg;
                        base_y_reg <= prev_y_reg;
                        sx_reg     <= (CW+1)'(in_vx) - (CW+1)'(prev_x_reg);
                        sy_reg     <= (CW+1)'(in_vy) - (CW+1)'(prev_y_reg);
                        ex_reg     <= (CW+1)'(qx_reg) - (CW+1)'(prev_x_reg);
                        ey_reg     <= (CW+1)'(qy_reg) - (CW+1)'(prev_y_reg);
                        prev_x_reg <= in_vx;
                        prev_y_reg <= in_vy;
                        cand_x_reg <= in_vx;
                        cand_y_reg <= in_vy;
                        foot_reg   <= 1'b0;
                        if (s_first_vertex) begin
                            qx_reg    <= s_query_x[CW-1:0];
                            qy_reg    <= s_query_y[CW-1:0];
                            state_reg <= ST_D1;
                        end else begin
                            state_reg <= ST_LEN1;
                        end
                    end
                end
                ST_LEN1: state_reg <= ST_LEN2;
                ST_LEN2: begin
                    acc_reg   <= AW'(prod);
                    state_reg <= ST_LEN3;
                end
                ST_LEN3: begin
                    len_reg   <= sum[DW-1:0];
                    state_reg <= ST_DOT1;
                end
                ST_DOT1: begin
                    acc_reg   <= AW'(prod);
                    state_reg <= ST_DOT2;
                end
                ST_DOT2: begin
                    state_reg <= try_foot ? ST_DIV : ST_D1;
                end
                ST_DIV: begin
                    if (div_done) begin
                        t_reg     <= div_quot;
                        state_reg <= ST_FX;
                    end
                end
                ST_FX: state_reg <= ST_FY;
                ST_FY: begin
                    cand_x_reg <= CW'(PW'(base_x_reg) + foot_off);
                    state_reg  <= ST_FD;
                end
                ST_FD: begin
                    cand_y_reg <= CW'(PW'(base_y_reg) + foot_off);
                    foot_reg   <= 1'b1;
                    state_reg  <= ST_D1;
                end
                ST_D1: state_reg <= ST_D2;
                ST_D2: begin
                    acc_reg   <= AW'(prod);
                    state_reg <= ST_D3;
                end
                ST_D3: begin
                    // Keep the candidate when strictly closer, or always on a first vertex
                    if (first_reg || (sum[BW-1:0] < best_dist_reg)) begin
                        best_dist_reg <= sum[BW-1:0];
                        best_x_reg    <= cand_x_reg;
                        best_y_reg    <= cand_y_reg;
                    end
                    if (foot_reg) begin
                        cand_x_reg <= vx_reg;
                        cand_y_reg <= vy_reg;
                        foot_reg   <= 1'b0;
                        state_reg  <= ST_D1;
                    end else begin
                        state_reg  <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Raise valid on a loaded result, drop it once the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_snap_x_reg <= $signed(COORD_BITS'($unsigned(best_x_reg)));
            m_snap_y_reg <= $signed(COORD_BITS'($unsigned(best_y_reg)));
            m_dist_reg   <= best_dist_reg[2*CW:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_snap_x      = m_snap_x_reg;
    assign m_snap_y      = m_snap_y_reg;
    assign m_distance_sq = m_dist_reg;
endmodule
`default_nettype wire

// ===== sim/polyline_nearest_point_snap_tb.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_point_snap_tb
// Streams polylines into the snap block and checks each snapped point and
// squared distance against an in-bench predictor, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module polyline_nearest_point_snap_tb;
    localparam int CW = 16;
    localparam int RFB = 16;
    localparam int DW = 2 * CW + 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 2 * (RFB + 22) + 10;

    typedef struct packed {
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic                 first;
        logic                 last;
    } vertex_t;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic [DW-1:0]        dist_sq;
    } snap_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_query_x = '0, s_query_y = '0, s_vertex_x = '0, s_vertex_y = '0;
    logic s_first_vertex = 1'b0, s_last_vertex = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_snap_x, m_snap_y;
    logic [DW-1:0] m_distance_sq;

    polyline_nearest_point_snap #(.COORD_BITS(CW), .RATIO_FRAC_BITS(RFB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_query_x(s_query_x), .s_query_y(s_query_y),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y),
        .s_first_vertex(s_first_vertex), .s_last_vertex(s_last_vertex),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_snap_x(m_snap_x), .m_snap_y(m_snap_y), .m_distance_sq(m_distance_sq)
    );

    vertex_t pending_vertices[$];
    snap_t   expected_snaps[$];
    int      error_count = 0;
    int      snaps_checked = 0;
    int      vertices_sent = 0;
    int      idle_cycles = 0;
    bit      stimulus_done = 1'b0;
    bit      calm_phase = 1'b0;
    bit      hold_off_req = 1'b0;

    // Predictor state
    longint q_x, q_y, prev_x, prev_y, best_x, best_y;
    longint unsigned best_d;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        return longint'(dx * dx + dy * dy);
    endfunction

    // floor(num * 2^RFB / den), restoring division
    function automatic longint unsigned seg_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = num;
        if (r >= den) begin
            q = 1;
            r -= den;
        end
        for (int i = 0; i < RFB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint floor_scale(longint a, longint unsigned t);
        longint unsigned p;
        p = (a < 0 ? -a : a) * t;
        if (a >= 0) return longint'(p >> RFB);
        return -longint'((p + ((64'd1 << RFB) - 1)) >> RFB);
    endfunction

    function automatic void try_candidate(longint x, longint y, longint unsigned d);
        if (d < best_d) begin
            best_d = d;
            best_x = x;
            best_y = y;
        end
    endfunction

    // Advance the predictor by one vertex; queue a snap on the last vertex
    function automatic void predict_snap(vertex_t v);
        longint vx, vy, sx, sy, dot;
        longint unsigned len, t;
        snap_t s;
        vx = v.vx;
        vy = v.vy;
        if (v.first) begin
            q_x = v.qx;
            q_y = v.qy;
            best_x = vx;
            best_y = vy;
            best_d = sq_dist(q_x, q_y, vx, vy);
        end else begin
            sx = vx - prev_x;
            sy = vy - prev_y;
            len = longint'(sx * sx + sy * sy);
            if (len != 0) begin
                dot = (q_x - prev_x) * sx + (q_y - prev_y) * sy;
                if (dot >= 0 && longint'(dot) <= longint'(len)) begin
                    t = seg_ratio(dot, len);
                    try_candidate(prev_x + floor_scale(sx, t), prev_y + floor_scale(sy, t),
                        sq_dist(q_x, q_y, prev_x + floor_scale(sx, t),
                                prev_y + floor_scale(sy, t)));
                end
            end
            try_candidate(vx, vy, sq_dist(q_x, q_y, vx, vy));
        end
        prev_x = vx;
        prev_y = vy;
        if (v.last) begin
            s.sx = best_x[CW-1:0];
            s.sy = best_y[CW-1:0];
            s.dist_sq = best_d[DW-1:0];
            expected_snaps.push_back(s);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 255)) - 16'sd128;
            default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic vertex_t make_vertex(bit first, bit last, int mode);
        vertex_t v;
        v.qx = rand_coord(mode);
        v.qy = rand_coord(mode);
        v.vx = rand_coord(mode);
        v.vy = rand_coord(mode);
        v.first = first;
        v.last = last;
        return v;
    endfunction

    function automatic void push_v(int qx, int qy, int vx, int vy, bit f, bit l);
        vertex_t v;
        v.qx = qx; v.qy = qy; v.vx = vx; v.vy = vy; v.first = f; v.last = l;
        pending_vertices.push_back(v);
    endfunction

    // Fill the queue: directed cases, then random polylines
    initial begin
        int n, mode;
        // vertex and last before any first vertex
        push_v(5, 5, 100, -100, 0, 0);
        push_v(5, 5, 7, 7, 0, 1);
        // single vertex polyline
        push_v(-32768, -32768, 32767, 32767, 1, 1);
        push_v(32767, 32767, -32768, -32768, 1, 1);
        // foot inside segment, zero-length segment, foot at ends
        push_v(16, 160, 0, 0, 1, 0);
        push_v(0, 0, 320, 0, 0, 0);
        push_v(0, 0, 320, 0, 0, 0);
        push_v(0, 0, 320, 320, 0, 1);
        push_v(-5, 3, 0, 0, 1, 0);
        push_v(0, 0, -33, 17, 0, 0);
        push_v(0, 0, 32767, -32768, 0, 1);
        push_v(0, 0, 0, 0, 1, 0);
        push_v(0, 0, -32768, 32767, 0, 0);
        push_v(0, 0, 32767, -32768, 0, 1);
        // query fields ignored on later vertices
        push_v(1, 1, 10, 10, 1, 0);
        push_v(-32768, 32767, 20, -10, 0, 1);
        while (vertices_sent < 700) begin
            mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0);
            if ($urandom_range(0, 19) == 0) begin
                pending_vertices.push_back(make_vertex($urandom_range(0, 1),
                    $urandom_range(0, 1), mode));
                vertices_sent++;
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    pending_vertices.push_back(make_vertex(i == 0, i == n - 1, mode));
                vertices_sent += n;
            end
        end
    end

    // Reset, then let the run drain and conclude
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_vertices.size() < 80);
        calm_phase = 1'b1;
        wait (pending_vertices.size() == 0 && !s_valid);
        stimulus_done = 1'b1;
        wait (expected_snaps.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d snaps over %0d random vertices plus directed cases,",
                 snaps_checked, vertices_sent);
        $display("with idle bursts on both sides and a long result-side hold-off.");
        if (error_count == 0 && expected_snaps.size() == 0)
            $display("polyline_nearest_point_snap_tb: clean");
        else
            $display("polyline_nearest_point_snap_tb: errors");
        $finish;
    end

    // Driver: offer vertices, idle in random bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready)
                predict_snap({s_query_x, s_query_y, s_vertex_x, s_vertex_y,
                              s_first_vertex, s_last_vertex});
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_vertices.size() != 0) begin
                vertex_t v;
                v = pending_vertices.pop_front();
                {s_query_x, s_query_y, s_vertex_x, s_vertex_y, s_first_vertex,
                 s_last_vertex} <= v;
                s_valid <= 1'b1;
                if (!calm_phase && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall in bursts, one long hold-off, check each snap
    int stall = 0;
    int hold_off = 0;
    bit hold_off_done = 1'b0;
    always @(posedge aclk) begin
        snap_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_snaps.size() == 0) begin
                report_mismatch("unexpected snap_x", m_snap_x, 0);
            end else begin
                want = expected_snaps.pop_front();
                snaps_checked++;
                if (m_snap_x !== want.sx) report_mismatch("snap_x", m_snap_x, want.sx);
                if (m_snap_y !== want.sy) report_mismatch("snap_y", m_snap_y, want.sy);
                if (m_distance_sq !== want.dist_sq)
                    report_mismatch("distance_sq", m_distance_sq, want.dist_sq);
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_off_done && snaps_checked >= 30) begin
            hold_off_done <= 1'b1;
            hold_off <= 400;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            m_ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            stall <= $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("polyline_nearest_point_snap_tb: errors");
            $finish;
        end
    end
endmodule
